FILE: src/kmb_pkg.sv
package kmb_pkg;

	// Board side as held inside the block: wide enough for a 64-square side.
	localparam int SIDE_W = 7;

	// Move distance width and its saturation value.
	localparam int DIST_W = 10;
	localparam logic [DIST_W-1:0] DIST_MAX = 10'd1023;

	// Result status codes.
	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_UNREACH  = 2'd1;
	localparam logic [1:0] ST_OFFBOARD = 2'd2;

	// One query beat.
	typedef struct packed {
		logic [5:0] board_size;
		logic [5:0] start_row;
		logic [5:0] start_col;
		logic [5:0] target_row;
		logic [5:0] target_col;
	} query_t;

	// One result beat.
	typedef struct packed {
		logic [DIST_W-1:0] move_count;
		logic [1:0]        status;
	} result_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLR,
		OP_SEED,
		OP_DEQ,
		OP_EXAM,
		OP_ROW_RD,
		OP_ROW_CHK,
		OP_PUSH_B
	} dp_op_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		dp_op_t     op;
		logic       fin;
		logic [1:0] fin_code;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic offboard;
		logic clr_last;
		logic empty;
		logic hit;
		logic row_last;
		logic both_new;
		logic row_done;
	} dp_sts_t;

	// The eight knight moves are visited as four row offsets, each with two column offsets.
	function automatic logic signed [7:0] row_ofs(input logic [1:0] j);
		logic signed [7:0] v;
		unique case (j)
			2'd0: v = -8'sd2;
			2'd1: v = -8'sd1;
			2'd2: v = 8'sd1;
			default: v = 8'sd2;
		endcase
		return v;
	endfunction

	function automatic logic signed [7:0] col_ofs_a(input logic [1:0] j);
		logic signed [7:0] v;
		unique case (j)
			2'd0: v = -8'sd1;
			2'd1: v = -8'sd2;
			2'd2: v = -8'sd2;
			default: v = -8'sd1;
		endcase
		return v;
	endfunction

	function automatic logic signed [7:0] col_ofs_b(input logic [1:0] j);
		logic signed [7:0] v;
		unique case (j)
			2'd0: v = 8'sd1;
			2'd1: v = 8'sd2;
			2'd2: v = 8'sd2;
			default: v = 8'sd1;
		endcase
		return v;
	endfunction

endpackage

FILE: src/kmb_dp.sv
module kmb_dp #(
	parameter int MAX_SIDE = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  kmb_pkg::query_t  query,
	input  kmb_pkg::dp_cmd_t cmd,
	output kmb_pkg::dp_sts_t sts,
	output kmb_pkg::result_t result
);
	import kmb_pkg::*;

	localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int SQ = MAX_SIDE * MAX_SIDE;
	localparam int AW = (SQ > 1) ? $clog2(SQ) : 1;
	localparam int PW = $clog2(SQ + 1);
	localparam int EW = 2 * CW + DIST_W;

	// Visited map, one row of bits per word; pending-square FIFO storage.
	logic [MAX_SIDE-1:0] vis_mem [MAX_SIDE];
	logic [EW-1:0]       pend_mem [SQ];

	logic [SIDE_W-1:0]   n_q;
	logic [5:0]          sr_q, sc_q, tr_q, tc_q;
	logic [CW-1:0]       clr_q;
	logic [PW-1:0]       head_q, tail_q;
	logic [CW-1:0]       cur_r_q, cur_c_q;
	logic [DIST_W-1:0]   cur_d_q;
	logic [1:0]          j_q;
	logic [CW-1:0]       nrow_q;
	logic                row_ok_q;
	logic [MAX_SIDE-1:0] vis_rdata_q;
	logic [EW-1:0]       pend_rdata_q;
	logic [EW-1:0]       pushb_q;
	result_t             result_q;

	logic [CW-1:0]       sr0, sc0;
	logic [SIDE_W-1:0]   tr0, tc0;
	logic [CW-1:0]       e_r, e_c;
	logic [DIST_W-1:0]   e_d, ndist;
	logic signed [7:0]   nr, ca, cb;
	logic                row_ok, ca_ok, cb_ok, new_a, new_b;
	logic [CW-1:0]       nr_idx, ca_idx, cb_idx;
	logic [EW-1:0]       ent_a, ent_b;
	logic                vis_we, pend_we;
	logic [CW-1:0]       vis_waddr;
	logic [MAX_SIDE-1:0] vis_wdata;
	logic [EW-1:0]       pend_wdata;

	function automatic logic on_board(input logic [5:0] x, input logic [SIDE_W-1:0] n);
		return (x != 6'd0) && (SIDE_W'(x) <= n);
	endfunction

	// Zero-based start and target coordinates.
	assign sr0 = CW'(sr_q - 6'd1);
	assign sc0 = CW'(sc_q - 6'd1);
	assign tr0 = SIDE_W'(tr_q) - SIDE_W'(1);
	assign tc0 = SIDE_W'(tc_q) - SIDE_W'(1);

	// Fields of the entry just read from the FIFO.
	assign e_r = pend_rdata_q[EW-1 -: CW];
	assign e_c = pend_rdata_q[EW-CW-1 -: CW];
	assign e_d = pend_rdata_q[DIST_W-1:0];

	// Neighbor row for the current row offset.
	assign nr     = $signed(8'(cur_r_q)) + row_ofs(j_q);
	assign row_ok = (nr >= 8'sd0) && (nr < $signed(8'(n_q)));
	assign nr_idx = row_ok ? nr[CW-1:0] : '0;

	// The two neighbor columns on that row, tested against the row just read.
	assign ca     = $signed(8'(cur_c_q)) + col_ofs_a(j_q);
	assign cb     = $signed(8'(cur_c_q)) + col_ofs_b(j_q);
	assign ca_ok  = (ca >= 8'sd0) && (ca < $signed(8'(n_q)));
	assign cb_ok  = (cb >= 8'sd0) && (cb < $signed(8'(n_q)));
	assign ca_idx = ca_ok ? ca[CW-1:0] : '0;
	assign cb_idx = cb_ok ? cb[CW-1:0] : '0;
	assign new_a  = row_ok_q && ca_ok && !vis_rdata_q[ca_idx];
	assign new_b  = row_ok_q && cb_ok && !vis_rdata_q[cb_idx];

	// Distance of the neighbors, saturating.
	assign ndist = (cur_d_q == DIST_MAX) ? DIST_MAX : cur_d_q + DIST_W'(1);
	assign ent_a = {nrow_q, ca_idx, ndist};
	assign ent_b = {nrow_q, cb_idx, ndist};

	// Status back to the controller.
	assign sts.offboard = !(on_board(sr_q, n_q) && on_board(sc_q, n_q) &&
		on_board(tr_q, n_q) && on_board(tc_q, n_q));
	assign sts.clr_last = (clr_q == CW'(MAX_SIDE - 1));
	assign sts.empty    = (head_q == tail_q);
	assign sts.hit      = (SIDE_W'(e_r) == tr0) && (SIDE_W'(e_c) == tc0);
	assign sts.row_last = (j_q == 2'd3);
	assign sts.both_new = new_a && new_b;
	assign sts.row_done = (j_q == 2'd0);

	assign result = result_q;

	// Visited map write port selection.
	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = clr_q;
		vis_wdata = '0;
		unique case (cmd.op)
			OP_CLR: begin
				vis_we = 1'b1;
			end
			OP_SEED: begin
				vis_we    = 1'b1;
				vis_waddr = sr0;
				vis_wdata = MAX_SIDE'(1) << sc0;
			end
			OP_ROW_CHK: begin
				vis_we    = new_a || new_b;
				vis_waddr = nrow_q;
				vis_wdata = vis_rdata_q | (MAX_SIDE'(new_a) << ca_idx) |
					(MAX_SIDE'(new_b) << cb_idx);
			end
			default: begin
			end
		endcase
	end

	// FIFO write port selection.
	always_comb begin
		pend_we    = 1'b0;
		pend_wdata = pushb_q;
		unique case (cmd.op)
			OP_SEED: begin
				pend_we    = 1'b1;
				pend_wdata = {sr0, sc0, DIST_W'(0)};
			end
			OP_ROW_CHK: begin
				pend_we    = new_a || new_b;
				pend_wdata = new_a ? ent_a : ent_b;
			end
			OP_PUSH_B: begin
				pend_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Visited map storage with a registered row read.
	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
		if (cmd.op == OP_ROW_RD) begin
			vis_rdata_q <= vis_mem[nr_idx];
		end
	end

	// FIFO storage with a registered head read. A seed always writes entry zero.
	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[(cmd.op == OP_SEED) ? AW'(0) : tail_q[AW-1:0]] <= pend_wdata;
		end
		if (cmd.op == OP_DEQ) begin
			pend_rdata_q <= pend_mem[head_q[AW-1:0]];
		end
	end

	// Query fields, current square and result.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			n_q  <= (SIDE_W'(query.board_size) > SIDE_W'(MAX_SIDE)) ?
				SIDE_W'(MAX_SIDE) : SIDE_W'(query.board_size);
			sr_q <= query.start_row;
			sc_q <= query.start_col;
			tr_q <= query.target_row;
			tc_q <= query.target_col;
		end
		if (cmd.op == OP_EXAM) begin
			cur_r_q <= e_r;
			cur_c_q <= e_c;
			cur_d_q <= e_d;
		end
		if (cmd.op == OP_ROW_RD) begin
			nrow_q   <= nr_idx;
			row_ok_q <= row_ok;
		end
		if (cmd.op == OP_ROW_CHK) begin
			pushb_q <= ent_b;
		end
		if (cmd.fin) begin
			result_q.move_count <= (cmd.fin_code == ST_FOUND) ? e_d : '0;
			result_q.status     <= cmd.fin_code;
		end
	end

	// Queue pointers, clear counter and move-row index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			clr_q  <= '0;
			j_q    <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD:  clr_q <= '0;
				OP_CLR:   clr_q <= clr_q + CW'(1);
				OP_SEED: begin
					head_q <= '0;
					tail_q <= PW'(1);
				end
				OP_DEQ:   head_q <= head_q + PW'(1);
				OP_EXAM:  j_q <= '0;
				OP_ROW_CHK: begin
					j_q <= j_q + 2'd1;
					if (new_a || new_b) begin
						tail_q <= tail_q + PW'(1);
					end
				end
				OP_PUSH_B: tail_q <= tail_q + PW'(1);
				default: begin
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("FIFO head passed tail");
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= PW'(SQ))
		else $error("FIFO holds more squares than the board");
	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DEQ |-> head_q != tail_q)
		else $error("dequeue from an empty FIFO");
`endif

endmodule

FILE: src/kmb_ctrl.sv
module kmb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output kmb_pkg::dp_cmd_t  cmd,
	input  kmb_pkg::dp_sts_t  sts
);
	import kmb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCREEN,
		S_CLEAR,
		S_SEED,
		S_DEQ,
		S_EXAM,
		S_ROW_RD,
		S_ROW_CHK,
		S_PUSH_B
	} state_t;

	state_t state_q;
	logic   done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// Datapath command for the current state.
	always_comb begin
		cmd.op       = OP_NONE;
		cmd.fin      = 1'b0;
		cmd.fin_code = ST_FOUND;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = OP_LOAD;
				end
			end
			S_SCREEN: begin
				if (sts.offboard) begin
					cmd.fin      = 1'b1;
					cmd.fin_code = ST_OFFBOARD;
				end
			end
			S_CLEAR: cmd.op = OP_CLR;
			S_SEED:  cmd.op = OP_SEED;
			S_DEQ: begin
				if (sts.empty) begin
					cmd.fin      = 1'b1;
					cmd.fin_code = ST_UNREACH;
				end else begin
					cmd.op = OP_DEQ;
				end
			end
			S_EXAM: begin
				if (sts.hit) begin
					cmd.fin      = 1'b1;
					cmd.fin_code = ST_FOUND;
				end else begin
					cmd.op = OP_EXAM;
				end
			end
			S_ROW_RD:  cmd.op = OP_ROW_RD;
			S_ROW_CHK: cmd.op = OP_ROW_CHK;
			S_PUSH_B:  cmd.op = OP_PUSH_B;
			default: begin
			end
		endcase
	end

	// Search sequencing and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCREEN;
					end
				end
				S_SCREEN: state_q <= sts.offboard ? S_IDLE : S_CLEAR;
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_SEED;
					end
				end
				S_SEED:  state_q <= S_DEQ;
				S_DEQ:   state_q <= sts.empty ? S_IDLE : S_EXAM;
				S_EXAM:  state_q <= sts.hit ? S_IDLE : S_ROW_RD;
				S_ROW_RD: state_q <= S_ROW_CHK;
				S_ROW_CHK: begin
					if (sts.both_new) begin
						state_q <= S_PUSH_B;
					end else if (sts.row_last) begin
						state_q <= S_DEQ;
					end else begin
						state_q <= S_ROW_RD;
					end
				end
				S_PUSH_B: state_q <= sts.row_done ? S_DEQ : S_ROW_RD;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe while a search is running");
	a_accept_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> state_q == S_SCREEN)
		else $error("accepted query did not enter screening");
	a_push_b_origin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUSH_B |-> $past(state_q) == S_ROW_CHK && $past(sts.both_new))
		else $error("second push without two new neighbors");
`endif

endmodule

FILE: src/knight_move_grid_bfs_distance.sv
// Knight minimum-move search. A query beat is taken at a clock edge where start is high and
// busy is low; busy then stays high until the answer is ready. The answer appears on result
// with done high for exactly one cycle, and the receiver cannot stall it, so it must be
// captured in that cycle. busy falls together with done, and a new query may be started in
// that same cycle. A query with the start or target off the board is answered from the
// screening state, without clearing. Otherwise the visited map is cleared one row a cycle,
// all MAX_SIDE rows, and the breadth-first search then steps through a FIFO read, a target
// check, and a read and an update of the visited map for each of the four neighbor rows,
// on each dequeued square, plus a second FIFO push for each neighbor row that yields two
// new squares, since the FIFO has a single write port. No clearing pass is needed
// after reset.
module knight_move_grid_bfs_distance #(
	parameter int MAX_SIDE = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  kmb_pkg::query_t  query,
	output logic             done,
	output kmb_pkg::result_t result
);
	import kmb_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer.
	kmb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	// Visited map, FIFO and neighbor arithmetic.
	kmb_dp #(
		.MAX_SIDE (MAX_SIDE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule
